[hw/rtl/lfpd_pkg.sv]
// Package for the PD line-follower steering block: widths, hold constants,
// sensor weights, sequencer states and output codes. No dependencies.
`default_nettype none
package lfpd_pkg;

    localparam int READING_BITS = 12;
    localparam int SPIN_HOLD_MS = 700;
    localparam int STOP_HOLD_MS = 10000;

    localparam int RD_W   = READING_BITS;
    localparam int SUM_W  = RD_W + 3;           // eight readings
    localparam int ERR_W  = RD_W + 7;           // |weights| on each side sum to 43
    localparam int DIF_W  = ERR_W + 1;
    localparam int MAG_W  = ERR_W + 17;         // |P + D| in Q.16
    localparam int HALF_W = (MAG_W + 1) / 2;    // magnitude split for the scale multiply
    localparam int GB_W   = 17;                 // 16-bit unsigned gain as signed operand
    localparam int AW_0   = (DIF_W > HALF_W + 1) ? DIF_W : HALF_W + 1;
    localparam int AW     = (AW_0 > RD_W + 1) ? AW_0 : RD_W + 1;
    localparam int PW     = AW + GB_W;
    localparam int ACC_W  = MAG_W + 17;
    localparam int FRAC_W = 32;                 // offset is Q.32
    localparam int OFFI_W = ACC_W - 1 - FRAC_W;
    localparam int THR_W  = 15;
    localparam int CMP_W  = (SUM_W > THR_W) ? SUM_W : THR_W;

    localparam int DUTY_W = 8;
    localparam int HOLD_W = 14;
    localparam int HOLD_MAX = 16383;
    localparam logic [HOLD_W-1:0] SPIN_HOLD =
        HOLD_W'((SPIN_HOLD_MS > HOLD_MAX) ? HOLD_MAX : SPIN_HOLD_MS);
    localparam logic [HOLD_W-1:0] STOP_HOLD =
        HOLD_W'((STOP_HOLD_MS > HOLD_MAX) ? HOLD_MAX : STOP_HOLD_MS);

    localparam logic signed [GB_W-1:0] WEIGHTS [8] = '{
        -17'sd20, -17'sd14, -17'sd7, -17'sd2, 17'sd2, 17'sd7, 17'sd14, 17'sd20
    };

    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_DERIV_GAIN  = 3'd1,
        CFG_OFFSET_SCL  = 3'd2,
        CFG_BASE_DUTY   = 3'd3,
        CFG_MAX_DUTY    = 3'd4,
        CFG_DEAD_BAND   = 3'd5,
        CFG_CROSS_THR   = 3'd6,
        CFG_SPIN_DUTY   = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        WAY_STRAIGHT = 2'd0,
        WAY_BELOW    = 2'd1,
        WAY_ABOVE    = 2'd2
    } way_t;

    typedef enum logic [1:0] {
        ACT_DRIVE = 2'd0,
        ACT_SPIN  = 2'd1,
        ACT_STOP  = 2'd2
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WSUM,
        ST_GAIN_P,
        ST_GAIN_D,
        ST_ABS,
        ST_OFF_LO,
        ST_OFF_HI,
        ST_EMIT,
        ST_EMIT2
    } state_t;

endpackage
`default_nettype wire

[hw/rtl/line_follow_pd_steering.sv]
// PD line-follower steering: weighted position error, PD drive term, duty
// offset, dead band and crossing-line spin/stop, on one shared multiplier.
// Depends on lfpd_pkg.
//
//   channel | signals                              | dir | handshake
//   --------+--------------------------------------+-----+--------------------
//   in      | reading_0..reading_7                 | in  | in_valid/in_ready
//   out     | left/right_duty, left/right_reverse, | out | out_valid/out_ready
//           | steer_way, action, hold_time_ms,     |     |
//           | last_of_run                          |     |
//   cfg     | cfg_index, cfg_data                  | in  | cfg_write, no wait
//
// A request passes from acceptance to its first result in the output register
// through eight multiply-accumulate steps for the weighted sum, two for the
// PD gains, one for the magnitude, two for the offset scale and one to resolve.
// The single signed multiplier with its accumulator sets that sequence.
// A crossing that spins adds a second result once the first is taken.
// in_ready is low while a request is in work; a full output stalls the
// resolve step. Reset restores the register defaults and clears history.
`default_nettype none
module line_follow_pd_steering (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_write,
    input  wire [2:0]                    cfg_index,
    input  wire [15:0]                   cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_0,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_1,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_2,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_3,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_4,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_5,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_6,
    input  wire [lfpd_pkg::RD_W-1:0]     reading_7,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [lfpd_pkg::DUTY_W-1:0]  left_duty,
    output logic [lfpd_pkg::DUTY_W-1:0]  right_duty,
    output logic                         left_reverse,
    output logic                         right_reverse,
    output logic [1:0]                   steer_way,
    output logic [1:0]                   action,
    output logic [lfpd_pkg::HOLD_W-1:0]  hold_time_ms,
    output logic                         last_of_run
);
    import lfpd_pkg::*;

    // configuration
    logic [15:0]       prop_reg, deriv_reg, scale_reg;
    logic [7:0]        base_reg, max_reg, spin_duty_reg;
    logic [9:0]        band_reg;
    logic [THR_W-1:0]  thr_reg;

    // sequencer and history
    state_t            state_reg, state_next;
    logic [2:0]        idx_reg, idx_next;
    logic              spun_reg, spun_next;
    logic signed [ERR_W-1:0] prev_reg, prev_next;

    // datapath
    logic [RD_W-1:0]          rd_reg [8];
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     shift_en, load_en;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_load;
    logic [DUTY_W-1:0]        ld_reg, rd_duty_reg, ld_next, rd_duty_next;
    logic                     lrev_reg, rrev_reg, lrev_next, rrev_next;
    way_t                     way_reg, way_next;
    act_t                     act_reg, act_next;
    logic [HOLD_W-1:0]        hold_reg, hold_next;
    logic                     last_reg, last_next;

    // shared multiplier
    logic signed [AW-1:0]     mult_a;
    logic signed [GB_W-1:0]   mult_b;
    logic signed [PW-1:0]     prod;
    logic signed [DIF_W-1:0]  diff;

    // resolve step
    logic [OFFI_W-1:0]        off_int;
    logic [OFFI_W:0]          off_ceil, fast_w;
    logic [7:0]               slow_d, fast_d;
    logic signed [DIF_W-1:0]  err_x, band_x;
    way_t                     way_c;
    logic                     crossing, out_free;

    assign prod = mult_a * mult_b;
    assign diff = DIF_W'(err_reg) - DIF_W'(prev_reg);

    // duty offset, steering direction, crossing detect and output-free flag
    always_comb
    begin
        off_int  = acc_reg[ACC_W-2:FRAC_W];
        off_ceil = {1'b0, off_int} + (OFFI_W+1)'(|acc_reg[FRAC_W-1:0]);
        if (off_ceil >= (OFFI_W+1)'(base_reg))
            slow_d = '0;
        else
            slow_d = base_reg - off_ceil[7:0];
        if (slow_d > max_reg)
            slow_d = max_reg;
        fast_w = {1'b0, off_int} + (OFFI_W+1)'(base_reg);
        if (fast_w > (OFFI_W+1)'(max_reg))
            fast_d = max_reg;
        else
            fast_d = fast_w[7:0];

        err_x  = DIF_W'(err_reg);
        band_x = DIF_W'($signed({1'b0, band_reg}));
        if (err_x > band_x)
            way_c = WAY_ABOVE;
        else if (err_x < -band_x)
            way_c = WAY_BELOW;
        else
            way_c = WAY_STRAIGHT;

        crossing = CMP_W'(sum_reg) > CMP_W'(thr_reg);
        out_free = !out_valid_reg || out_ready;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        spun_next      = spun_reg;
        prev_next      = prev_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        mag_next       = mag_reg;
        shift_en       = 1'b0;
        load_en        = 1'b0;
        mult_a         = AW'($signed({1'b0, rd_reg[0]}));
        mult_b         = WEIGHTS[idx_reg];
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        ld_next        = base_reg;
        rd_duty_next   = base_reg;
        lrev_next      = 1'b0;
        rrev_next      = 1'b0;
        way_next       = WAY_STRAIGHT;
        act_next       = ACT_DRIVE;
        hold_next      = '0;
        last_next      = 1'b1;
        in_ready       = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    load_en    = 1'b1;
                    acc_next   = '0;
                    sum_next   = '0;
                    idx_next   = '0;
                    state_next = ST_WSUM;
                end
            end
            ST_WSUM:
            begin
                acc_next = acc_reg + ACC_W'(prod);
                sum_next = sum_reg + SUM_W'(rd_reg[0]);
                shift_en = 1'b1;
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                    state_next = ST_GAIN_P;
            end
            ST_GAIN_P:
            begin
                err_next   = acc_reg[ERR_W-1:0];
                mult_a     = AW'($signed(acc_reg[ERR_W-1:0]));
                mult_b     = $signed({1'b0, prop_reg});
                acc_next   = ACC_W'(prod);
                state_next = ST_GAIN_D;
            end
            ST_GAIN_D:
            begin
                mult_a     = AW'(diff);
                mult_b     = $signed({1'b0, deriv_reg});
                acc_next   = acc_reg + ACC_W'(prod);
                prev_next  = err_reg;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                mag_next   = acc_reg[ACC_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
                state_next = ST_OFF_LO;
            end
            ST_OFF_LO:
            begin
                mult_a     = AW'($signed({1'b0, mag_reg[HALF_W-1:0]}));
                mult_b     = $signed({1'b0, scale_reg});
                acc_next   = ACC_W'(prod);
                state_next = ST_OFF_HI;
            end
            ST_OFF_HI:
            begin
                mult_a     = AW'($signed({1'b0, mag_reg[MAG_W-1:HALF_W]}));
                mult_b     = $signed({1'b0, scale_reg});
                acc_next   = acc_reg + (ACC_W'(prod) <<< HALF_W);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (crossing && !spun_reg)
                    begin
                        spun_next    = 1'b1;
                        ld_next      = spin_duty_reg;
                        rd_duty_next = spin_duty_reg;
                        lrev_next    = 1'b1;
                        act_next     = ACT_SPIN;
                        hold_next    = SPIN_HOLD;
                        last_next    = 1'b0;
                        state_next   = ST_EMIT2;
                    end
                    else if (crossing)
                    begin
                        ld_next      = '0;
                        rd_duty_next = '0;
                        act_next     = ACT_STOP;
                        hold_next    = STOP_HOLD;
                    end
                    else
                    begin
                        way_next = way_c;
                        if (way_c == WAY_BELOW)
                        begin
                            ld_next      = fast_d;
                            rd_duty_next = slow_d;
                        end
                        else if (way_c == WAY_ABOVE)
                        begin
                            ld_next      = slow_d;
                            rd_duty_next = fast_d;
                        end
                    end
                end
            end
            ST_EMIT2:
            begin
                // straight drive after the spin, base duty on both wheels
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            spun_reg      <= 1'b0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            prop_reg      <= 16'd2621;
            deriv_reg     <= 16'd26214;
            scale_reg     <= 16'd1928;
            base_reg      <= 8'd60;
            max_reg       <= 8'd90;
            band_reg      <= 10'd1;
            thr_reg       <= 15'd19000;
            spin_duty_reg <= 8'd70;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            spun_reg      <= spun_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PROP_GAIN:  prop_reg      <= cfg_data;
                    CFG_DERIV_GAIN: deriv_reg     <= cfg_data;
                    CFG_OFFSET_SCL: scale_reg     <= cfg_data;
                    CFG_BASE_DUTY:  base_reg      <= cfg_data[7:0];
                    CFG_MAX_DUTY:   max_reg       <= cfg_data[7:0];
                    CFG_DEAD_BAND:  band_reg      <= cfg_data[9:0];
                    CFG_CROSS_THR:  thr_reg       <= cfg_data[THR_W-1:0];
                    CFG_SPIN_DUTY:  spin_duty_reg <= cfg_data[7:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sum_reg <= sum_next;
        err_reg <= err_next;
        mag_reg <= mag_next;
        if (load_en)
        begin
            rd_reg[0] <= reading_0;
            rd_reg[1] <= reading_1;
            rd_reg[2] <= reading_2;
            rd_reg[3] <= reading_3;
            rd_reg[4] <= reading_4;
            rd_reg[5] <= reading_5;
            rd_reg[6] <= reading_6;
            rd_reg[7] <= reading_7;
        end
        else if (shift_en)
        begin
            for (int i = 0; i < 7; i++)
                rd_reg[i] <= rd_reg[i+1];
            rd_reg[7] <= rd_reg[0];
        end
        if (out_load)
        begin
            ld_reg      <= ld_next;
            rd_duty_reg <= rd_duty_next;
            lrev_reg    <= lrev_next;
            rrev_reg    <= rrev_next;
            way_reg     <= way_next;
            act_reg     <= act_next;
            hold_reg    <= hold_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign left_duty     = ld_reg;
    assign right_duty    = rd_duty_reg;
    assign left_reverse  = lrev_reg;
    assign right_reverse = rrev_reg;
    assign steer_way     = way_reg;
    assign action        = act_reg;
    assign hold_time_ms  = hold_reg;
    assign last_of_run   = last_reg;

    a_accept_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_WSUM && idx_reg == 3'd0)
        else $error("accepted request did not start the weighted sum");

    a_spun_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        spun_reg |=> spun_reg)
        else $error("spin flag cleared outside reset");

    a_stop_after_spin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_STOP |-> spun_reg)
        else $error("stop issued before any spin");

    a_way_only_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && steer_way != WAY_STRAIGHT |-> action == ACT_DRIVE)
        else $error("steering direction on a spin or stop result");

    a_first_is_spin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> action == ACT_SPIN && state_reg == ST_EMIT2)
        else $error("non-final result that is not a spin");

endmodule
`default_nettype wire
